@@ rtl/core/pli_pkg.sv @@
// Shared types and constants of the piecewise linear interpolator.
`default_nettype none
package pli_pkg;
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_DECREASE  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FEW       = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    localparam int DATA_W = 32;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic clear;       // empty the table
        logic rd_last;     // read the last knot time
        logic rd_first;    // read the first knot time
        logic rd_mid;      // read the knot time at the search midpoint
        logic search_init; // start a binary search
        logic search_step; // apply one search comparison
        logic rd_seg;      // read segment offset, slope and start time
        logic div_start;   // start the slope division
        logic div_step;    // advance the division by one bit
        logic write_knot;  // store the new knot and its segment
        logic mul_lo;      // form dt and clear the low partial product
        logic mul_hi;      // form both partial products
        logic finish;      // form the interpolated value
        logic set_status;  // latch status code
        logic out_load;    // hand the result to the output register
        status_t status;
    } pli_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        opcode_t opcode;
        logic    count_zero;
        logic    count_lt2;
        logic    full;
        logic    t_lt_mem;   // sample time below the knot time just read
        logic    t_eq_mem;   // sample time equal to the knot time just read
        logic    t_gt_mem;
        logic    search_done;
        logic    div_done;
    } pli_stat_t;
endpackage
`default_nettype wire

@@ rtl/core/pli_if.sv @@
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface pli_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pli_ctrl.sv @@
// Controller state machine of the piecewise linear interpolator.
`default_nettype none
module pli_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire pli_pkg::pli_stat_t stat,
    output pli_pkg::pli_cmd_t    cmd
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_APP_CHK, S_DIV, S_APP_WR,
        S_Q_FIRST, S_Q_LAST, S_Q_CHK, S_SEARCH_RD, S_SEARCH_CMP,
        S_SEG_RD, S_MUL_LO, S_MUL_HI, S_FINISH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.status     = ST_OK;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.opcode)
                    OP_CLEAR:
                    begin
                        cmd.clear      = 1'b1;
                        cmd.set_status = 1'b1;
                        state_next     = S_OUT;
                    end
                    OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_APP_CHK;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (stat.count_lt2)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FEW;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_Q_FIRST;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        state_next     = S_OUT;
                    end
                endcase
            end
            S_APP_CHK:
            begin
                if (!stat.count_zero && stat.t_lt_mem)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DECREASE;
                    state_next     = S_OUT;
                end
                else if (!stat.count_zero && stat.t_eq_mem)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DUPLICATE;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_APP_WR;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_APP_WR:
            begin
                cmd.write_knot = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_OUT;
            end
            S_Q_FIRST:
            begin
                if (stat.t_lt_mem)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_RANGE;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_Q_LAST;
                end
            end
            S_Q_LAST:
            begin
                if (stat.t_gt_mem)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_RANGE;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_Q_CHK;
                end
            end
            S_Q_CHK:
            begin
                if (stat.search_done)
                begin
                    cmd.rd_seg = 1'b1;
                    state_next = S_SEG_RD;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD:
            begin
                state_next = S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                cmd.search_step = 1'b1;
                state_next      = S_Q_CHK;
            end
            S_SEG_RD:
            begin
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish     = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DECODE)
        else $error("load did not enter decode");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_knot |-> $past(state_reg) == S_DIV)
        else $error("knot written without division");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input accepted while busy");
endmodule
`default_nettype wire

@@ rtl/core/pli_datapath.sv @@
// Datapath of the piecewise linear interpolator: knot memories, divider, multiplier.
`default_nettype none
module pli_datapath #(
    parameter int MAX_KNOTS = 256,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            in_opcode,
    input  wire logic signed [31:0]    in_time,
    input  wire logic signed [31:0]    in_value,
    input  wire pli_pkg::pli_cmd_t     cmd,
    output pli_pkg::pli_stat_t         stat,
    output logic signed [31:0]         result_value,
    output logic [2:0]                 status
);
    import pli_pkg::*;

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int NUM_W = 33 + FRAC_BITS;  // magnitude of value delta << FRAC_BITS
    localparam int DEN_W = 33;
    localparam int DCW = $clog2(NUM_W + 1);

    logic signed [31:0] time_mem   [MAX_KNOTS];
    logic signed [31:0] offset_mem [MAX_KNOTS];
    logic signed [31:0] slope_mem  [MAX_KNOTS];

    logic [1:0]         opcode_reg;
    logic signed [31:0] t_reg, v_reg;
    logic signed [31:0] last_value_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] mem_time_reg;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    // Search bounds: lo and hi indexes.
    logic [CW-1:0]      lo_reg, hi_reg;
    logic [CW-1:0]      mid;

    // Division state.
    logic [NUM_W-1:0]   quo_reg;
    logic [DEN_W:0]     rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic signed [32:0] h_full;
    logic signed [32:0] diff_full;
    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_sub;
    logic signed [31:0] slope_sat;

    // Query state.
    logic signed [31:0] seg_off_reg, seg_slope_reg, seg_t_reg;
    logic signed [32:0] dt_reg;
    logic signed [49:0] plo_reg;
    logic signed [47:0] phi_val;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_full;
    logic signed [65:0] q_val;
    logic signed [66:0] sum_val;
    logic signed [31:0] result_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] out_result_reg;
    logic [2:0]         out_status_reg;
    logic [CW-1:0]      seg_k;
    logic [CW-1:0]      seg_lo;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        rd_en   = cmd.rd_last | cmd.rd_first | cmd.rd_mid;
        rd_addr = '0;
        if (cmd.rd_last)
        begin
            rd_addr = AW'(count_reg - CW'(1));
        end
        else if (cmd.rd_mid)
        begin
            rd_addr = AW'(mid);
        end
    end

    // Segment choice: last knot uses last segment.
    always_comb
    begin
        seg_k  = hi_reg;
        seg_lo = lo_reg;
        if (hi_reg >= count_reg)
        begin
            seg_k  = count_reg - CW'(1);
            seg_lo = count_reg - CW'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_time_reg <= time_mem[rd_addr];
        end
        if (cmd.rd_seg)
        begin
            seg_off_reg   <= offset_mem[AW'(seg_k)];
            seg_slope_reg <= slope_mem[AW'(seg_k)];
            seg_t_reg     <= time_mem[AW'(seg_lo)];
        end
        if (cmd.write_knot)
        begin
            time_mem[AW'(count_reg)]   <= t_reg;
            offset_mem[AW'(count_reg)] <= last_value_reg;
            slope_mem[AW'(count_reg)]  <= slope_sat;
        end
    end

    assign h_full    = 33'(t_reg) - 33'(mem_time_reg);
    assign diff_full = 33'(v_reg) - 33'(last_value_reg);
    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // Saturate the truncated quotient to 32 signed bits; the first knot gets a zero slope.
    always_comb
    begin
        if (count_reg == '0)
        begin
            slope_sat = '0;
        end
        else if (!neg_reg)
        begin
            slope_sat = (quo_reg > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : 32'(quo_reg);
        end
        else
        begin
            slope_sat = (quo_reg >= NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                             : -32'(quo_reg);
        end
    end

    // High partial product: slope times the upper dt bits.
    assign phi_val   = seg_slope_reg * $signed({1'b0, dt_reg[32:17]});
    assign prod_full = prod_reg + 66'(plo_reg);

    // Floor shift of the product, then saturated sum.
    assign q_val   = prod_full >>> FRAC_BITS;
    assign sum_val = 67'(seg_off_reg) + 67'(q_val);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg <= in_opcode;
            t_reg      <= in_time;
            v_reg      <= in_value;
        end
        if (cmd.div_start)
        begin
            quo_reg     <= NUM_W'(diff_full[32] ? -diff_full : diff_full) << FRAC_BITS;
            den_reg     <= DEN_W'(h_full);
            neg_reg     <= diff_full[32];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DCW'(1);
            if (!rem_sub[DEN_W])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.rd_seg)
        begin
            dt_reg <= '0;
        end
        if (cmd.mul_lo)
        begin
            dt_reg  <= 33'(t_reg) - 33'(seg_t_reg);
            plo_reg <= '0;
        end
        if (cmd.mul_hi)
        begin
            // dt fits in 33 bits; split into low 17 and high 16 bit pieces.
            plo_reg  <= 50'(seg_slope_reg) * $signed({1'b0, dt_reg[16:0]});
            prod_reg <= 66'(phi_val) <<< 17;
        end
        if (cmd.finish)
        begin
            prod_reg <= '0;
        end
    end

    // Registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_value_reg <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            result_reg     <= '0;
            status_reg     <= ST_OK;
            out_result_reg <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg      <= '0;
                last_value_reg <= '0;
            end
            if (cmd.write_knot)
            begin
                count_reg      <= count_reg + CW'(1);
                last_value_reg <= v_reg;
            end
            if (cmd.search_init)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            if (cmd.search_step)
            begin
                if (mem_time_reg > t_reg)
                begin
                    hi_reg <= mid;
                end
                else
                begin
                    lo_reg <= mid;
                end
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.finish)
            begin
                if (sum_val > 67'sd2147483647)
                begin
                    result_reg <= 32'sh7FFF_FFFF;
                end
                else if (sum_val < -67'sd2147483648)
                begin
                    result_reg <= 32'sh8000_0000;
                end
                else
                begin
                    result_reg <= 32'(sum_val);
                end
            end
            else if (cmd.set_status)
            begin
                result_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_result_reg <= result_reg;
                out_status_reg <= status_reg;
            end
        end
    end

    assign stat.opcode      = opcode_t'(opcode_reg);
    assign stat.count_zero  = (count_reg == '0);
    assign stat.count_lt2   = (count_reg < CW'(2));
    assign stat.full        = (count_reg >= CW'(MAX_KNOTS));
    assign stat.t_lt_mem    = (t_reg < mem_time_reg);
    assign stat.t_eq_mem    = (t_reg == mem_time_reg);
    assign stat.t_gt_mem    = (t_reg > mem_time_reg);
    assign stat.search_done = (lo_reg + CW'(1) == hi_reg);
    assign stat.div_done    = (div_cnt_reg == DCW'(NUM_W));

    assign result_value = out_result_reg;
    assign status       = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KNOTS))
        else $error("knot count beyond table");
    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> lo_reg < hi_reg)
        else $error("search bounds crossed");
    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_knot |=> count_reg == $past(count_reg) + CW'(1))
        else $error("count did not advance");
endmodule
`default_nettype wire

@@ rtl/core/piecewise_linear_interpolator.sv @@
// Top level of the piecewise linear interpolator.
// Usage:
//   in  channel: transaction of {opcode, sample_time, sample_value}.
//     opcode clear empties the table, append adds a knot, query interpolates.
//   out channel: transaction of {result_value, status}, one per input transaction.
// Sequencing: clear and rejected commands go straight to the output; append
//   runs the bit-serial slope divider (33+FRAC_BITS steps); query does a
//   binary search over the knot-time memory read port, each step a check, a
//   read and a compare state, then the MUL_LO and MUL_HI multiply states.
// Throughput: one transaction at a time; the next input is taken once the
//   result has been placed in the output register.
// Reset: knot count and last value clear; memory contents stay undefined
//   and are not used before being written.
// Stall: a result waits in the output register while the receiver holds
//   ready low; the block holds until it can hand the next result over.
`default_nettype none
module piecewise_linear_interpolator #(
    parameter int MAX_KNOTS = 256,
    parameter int FRAC_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    pli_if.sink      in_ch,
    pli_if.source    out_ch
);
    import pli_pkg::*;

    pli_cmd_t  cmd;
    pli_stat_t stat;

    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pli_datapath #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_opcode    (in_ch.payload.opcode),
        .in_time      (in_ch.payload.sample_time),
        .in_value     (in_ch.payload.sample_value),
        .cmd          (cmd),
        .stat         (stat),
        .result_value (out_ch.payload.result_value),
        .status       (out_ch.payload.status)
    );
endmodule
`default_nettype wire
